@@ sv/bae_pkg.sv @@
// shared types, constants and checksum helpers of the bech32m address encoder
`timescale 1ns / 1ps

package bae_pkg;

   // queue between front and back
   localparam int unsigned BAE_QUEUE_DEPTH = 2;
   localparam int unsigned BAE_QPTR_W      = $clog2(BAE_QUEUE_DEPTH);
   localparam int unsigned BAE_QCNT_W      = $clog2(BAE_QUEUE_DEPTH + 1);

   // configuration register indexes (paddr[3:2])
   localparam logic [1:0] BAE_REG_PREFIX_FIRST  = 2'd0;
   localparam logic [1:0] BAE_REG_PREFIX_SECOND = 2'd1;
   localparam logic [1:0] BAE_REG_VERSION       = 2'd2;

   localparam logic [6:0] BAE_RST_PREFIX_FIRST  = 7'd98;
   localparam logic [6:0] BAE_RST_PREFIX_SECOND = 7'd99;
   localparam logic [4:0] BAE_RST_VERSION       = 5'd1;

   // separator character '1'
   localparam logic [6:0] BAE_SEP_CHAR = 7'h31;

   localparam logic [29:0] BAE_CHK_INIT   = 30'd1;
   localparam logic [29:0] BAE_BECH32M_XOR = 30'h2bc830a3;

   localparam logic [29:0] BAE_GEN [0:4] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };

   // "qpzry9x8gf2tvdw0s3jn54khce6mua7l"
   localparam logic [6:0] BAE_SYM_CHARS [0:31] = '{
      7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
      7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
      7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
      7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
   };

   typedef struct packed {
      logic [7:0] program_byte;
      logic       first;
      logic       last;
   } bae_item_type;

   typedef struct packed {
      logic [6:0] prefix_first_char;
      logic [6:0] prefix_second_char;
      logic [4:0] version_sym;
   } bae_cfg_type;

   typedef enum logic [3:0] {
      BAE_IDLE,
      BAE_PFX1,
      BAE_PFX2,
      BAE_SEP,
      BAE_VER,
      BAE_SYM,
      BAE_PAD,
      BAE_ZFOLD,
      BAE_CSUM
   } bae_state_type;

   // one polymod step
   function automatic logic [29:0] bae_fold(input logic [29:0] chk, input logic [4:0] sym);
      logic [4:0]  top;
      logic [29:0] res;
      top = chk[29:25];
      res = {chk[24:0], sym};
      for (int i = 0; i < 5; i++) begin
         if (top[i]) begin
            res = res ^ BAE_GEN[i];
         end
      end
      return res;
   endfunction

   function automatic logic [6:0] bae_sym_char(input logic [4:0] sym);
      return BAE_SYM_CHARS[sym];
   endfunction

endpackage

@@ sv/bae_ifs.sv @@
// valid/ready channel interfaces of the bech32m address encoder
`timescale 1ns / 1ps

interface bae_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] program_byte;

   modport source (output valid, output program_byte, input ready);
   modport sink (input valid, input program_byte, output ready);
endinterface

interface bae_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

@@ sv/bech32m_address_encoder_unit.sv @@
// top level of the bech32m address encoder
`timescale 1ns / 1ps

// streams the ascii characters of a bech32m address from a witness program
// req: one program byte per item, most significant first; PROGRAM_BYTES items
//   make one address, and the first and last byte are found by counting
// rsp: one character per item; last_char marks the final checksum character
// apb: prefix characters and witness version, read at the first byte
// front: byte counter tags each item and pushes it into a two-entry queue
// back: sequencer emits one character per cycle unless rsp stalls, the queue is empty or
//   zeros fold; one polymod step per symbol, two at once for prefix and trailing zeros
// characters: a middle byte yields 1 or 2 characters; the first byte adds 4
//   (prefix, separator, version), the last adds up to 1 pad character,
//   a zero folding phase and 6 checksum characters
// path: a byte passes the queue, sequencer state and output register
// reset: queue emptied, byte count and sequencer cleared, registers
//   back to 'b', 'c' and version 1
// rsp stall: the output register holds its item and the sequencer
//   freezes; bytes keep flowing into the queue until it is full

module bech32m_address_encoder_unit
   import bae_pkg::*;
#(
   parameter int unsigned PROGRAM_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   bae_req_if.sink     req,
   bae_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   bae_cfg_type  cfg_ff;
   bae_item_type push_item;
   bae_item_type pop_item;
   logic         push;
   logic         full;
   logic         pop;
   logic         pop_valid;
   logic         csr_write;
   logic [1:0]   csr_index;

   // register file; writes to unused addresses are dropped
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prefix_first_char  <= BAE_RST_PREFIX_FIRST;
         cfg_ff.prefix_second_char <= BAE_RST_PREFIX_SECOND;
         cfg_ff.version_sym        <= BAE_RST_VERSION;
      end else if (csr_write) begin
         unique case (csr_index)
            BAE_REG_PREFIX_FIRST:  cfg_ff.prefix_first_char  <= pwdata[6:0];
            BAE_REG_PREFIX_SECOND: cfg_ff.prefix_second_char <= pwdata[6:0];
            BAE_REG_VERSION:       cfg_ff.version_sym        <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         BAE_REG_PREFIX_FIRST:  prdata = {25'd0, cfg_ff.prefix_first_char};
         BAE_REG_PREFIX_SECOND: prdata = {25'd0, cfg_ff.prefix_second_char};
         BAE_REG_VERSION:       prdata = {27'd0, cfg_ff.version_sym};
         default:               prdata = 32'd0;
      endcase
   end

   // byte counting and classification
   bae_front #(
      .PROGRAM_BYTES (PROGRAM_BYTES)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_full (full),
      .q_push (push),
      .q_item (push_item)
   );

   // decouples input stalls from output stalls
   bae_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   // character sequencer and checksum
   bae_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (pop_valid),
      .q_item  (pop_item),
      .q_pop   (pop),
      .rsp     (rsp)
   );

endmodule

@@ sv/bae_front.sv @@
// front end: accepts program bytes and tags first and last byte of an address
`timescale 1ns / 1ps

module bae_front
   import bae_pkg::*;
#(
   parameter int unsigned PROGRAM_BYTES = 32
) (
   input  logic         clock,
   input  logic         reset,
   bae_req_if.sink      req,
   input  logic         q_full,
   output logic         q_push,
   output bae_item_type q_item
);

   localparam int unsigned POS_W = $clog2(PROGRAM_BYTES);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             is_last;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;
   assign is_last   = (pos_ff == POS_W'(PROGRAM_BYTES - 1));

   assign q_item.program_byte = req.program_byte;
   assign q_item.first        = (pos_ff == '0);
   assign q_item.last         = is_last;

   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         pos_in = is_last ? '0 : pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

@@ sv/bae_queue.sv @@
// short item queue between front and back
`timescale 1ns / 1ps

module bae_queue
   import bae_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bae_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         pop_valid,
   output bae_item_type pop_item
);

   bae_item_type          mem_ff [BAE_QUEUE_DEPTH];
   logic [BAE_QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [BAE_QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [BAE_QCNT_W-1:0] count_ff, count_in;
   logic                  do_pop;

   assign full      = (count_ff == BAE_QCNT_W'(BAE_QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == BAE_QPTR_W'(BAE_QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + BAE_QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == BAE_QPTR_W'(BAE_QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + BAE_QPTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + BAE_QCNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - BAE_QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/bae_back.sv @@
// back end: symbol sequencer, polymod checksum and output register
`timescale 1ns / 1ps

module bae_back
   import bae_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  bae_cfg_type  cfg,
   input  logic         q_valid,
   input  bae_item_type q_item,
   output logic         q_pop,
   bae_rsp_if.source    rsp
);

   bae_state_type state_ff, state_in;

   logic [29:0] chk_ff, chk_in;
   logic [29:0] sum_ff, sum_in;
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  bits_ff, bits_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;

   logic        rsp_valid_ff;
   logic [6:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        advance;
   logic        emit;
   logic        item_done;
   logic [3:0]  bits_nx;
   logic [4:0]  sym_cur;
   logic [2:0]  lo_cnt;
   logic [3:0]  lo_bits;
   logic [3:0]  pad_bits;
   logic [4:0]  pad_sym;
   bae_state_type load_state;

   assign advance    = !rsp_valid_ff || rsp.ready;
   assign bits_nx    = bits_ff - 4'd5;
   assign sym_cur    = 5'(acc_ff >> bits_nx);
   assign lo_cnt     = (state_ff == BAE_SYM) ? bits_nx[2:0] : bits_ff[2:0];
   assign lo_bits    = acc_ff[3:0] & ~(4'hF << lo_cnt);
   assign pad_bits   = acc_ff[3:0] & ~(4'hF << bits_ff[2:0]);
   assign pad_sym    = 5'({1'b0, pad_bits} << (3'd5 - bits_ff[2:0]));
   assign load_state = q_item.first ? BAE_PFX1 : BAE_SYM;
   // current item finishes this cycle, so the next one may be taken
   assign item_done  = (state_ff == BAE_IDLE)
                     || (state_ff == BAE_SYM && bits_nx < 4'd5 && !last_ff)
                     || (state_ff == BAE_CSUM && cnt_ff == 3'd5);
   assign q_pop      = advance && item_done && q_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BAE_IDLE: begin
            if (q_valid) begin
               state_in = load_state;
            end
         end
         BAE_PFX1: state_in = BAE_PFX2;
         BAE_PFX2: state_in = BAE_SEP;
         BAE_SEP:  state_in = BAE_VER;
         BAE_VER:  state_in = BAE_SYM;
         BAE_SYM: begin
            priority if (bits_nx >= 4'd5) begin
               state_in = BAE_SYM;
            end else if (last_ff) begin
               state_in = (bits_nx != 4'd0) ? BAE_PAD : BAE_ZFOLD;
            end else if (q_valid) begin
               state_in = load_state;
            end else begin
               state_in = BAE_IDLE;
            end
         end
         BAE_PAD: state_in = BAE_ZFOLD;
         BAE_ZFOLD: begin
            if (cnt_ff == 3'd2) begin
               state_in = BAE_CSUM;
            end
         end
         BAE_CSUM: begin
            if (cnt_ff == 3'd5) begin
               state_in = q_valid ? load_state : BAE_IDLE;
            end
         end
         default: state_in = BAE_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      chk_in      = chk_ff;
      sum_in      = sum_ff;
      acc_in      = acc_ff;
      bits_in     = bits_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      emit        = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = 1'b0;
      unique case (state_ff)
         BAE_IDLE: ;
         BAE_PFX1: begin
            // high parts of both prefix characters
            emit        = 1'b1;
            rsp_char_in = cfg.prefix_first_char;
            chk_in      = bae_fold(bae_fold(BAE_CHK_INIT, {3'b0, cfg.prefix_first_char[6:5]}),
                                   {3'b0, cfg.prefix_second_char[6:5]});
         end
         BAE_PFX2: begin
            // zero separator symbol, then low part of first char
            emit        = 1'b1;
            rsp_char_in = cfg.prefix_second_char;
            chk_in      = bae_fold(bae_fold(chk_ff, 5'd0), cfg.prefix_first_char[4:0]);
         end
         BAE_SEP: begin
            emit        = 1'b1;
            rsp_char_in = BAE_SEP_CHAR;
            chk_in      = bae_fold(chk_ff, cfg.prefix_second_char[4:0]);
         end
         BAE_VER: begin
            emit        = 1'b1;
            rsp_char_in = bae_sym_char(cfg.version_sym);
            chk_in      = bae_fold(chk_ff, cfg.version_sym);
         end
         BAE_SYM: begin
            emit        = 1'b1;
            rsp_char_in = bae_sym_char(sym_cur);
            chk_in      = bae_fold(chk_ff, sym_cur);
            bits_in     = bits_nx;
         end
         BAE_PAD: begin
            emit        = 1'b1;
            rsp_char_in = bae_sym_char(pad_sym);
            chk_in      = bae_fold(chk_ff, pad_sym);
         end
         BAE_ZFOLD: begin
            // six trailing zero symbols, two a cycle unless rsp stalls
            chk_in = bae_fold(bae_fold(chk_ff, 5'd0), 5'd0);
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd2) begin
               sum_in = chk_in ^ BAE_BECH32M_XOR;
               cnt_in = 3'd0;
            end
         end
         BAE_CSUM: begin
            emit        = 1'b1;
            rsp_char_in = bae_sym_char(sum_ff[29:25]);
            rsp_last_in = (cnt_ff == 3'd5);
            sum_in      = {sum_ff[24:0], 5'd0};
            cnt_in      = cnt_ff + 3'd1;
         end
         default: ;
      endcase

      if (q_pop) begin
         last_in = q_item.last;
         cnt_in  = 3'd0;
         if (q_item.first) begin
            acc_in  = {4'd0, q_item.program_byte};
            bits_in = 4'd8;
         end else begin
            acc_in  = {lo_bits, q_item.program_byte};
            bits_in = {1'b0, lo_cnt} + 4'd8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BAE_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         chk_ff      <= chk_in;
         sum_ff      <= sum_in;
         acc_ff      <= acc_in;
         bits_ff     <= bits_in;
         last_ff     <= last_in;
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.char_code = rsp_char_ff;
   assign rsp.last_char = rsp_last_ff;

endmodule

@@ sv/bae_checker.sv @@
// port-level checks of the bech32m address encoder and their bind
`timescale 1ns / 1ps

module bae_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_char_code,
   input logic       rsp_last_char
);

   // a stalled item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code)
                                  && $stable(rsp_last_char))
      else $error("rsp item changed under stall");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // an address is far longer than one character
   a_last_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_char |=> !(rsp_valid && rsp_last_char))
      else $error("two final characters in a row");

endmodule

bind bech32m_address_encoder_unit bae_checker u_bae_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_char_code (rsp.char_code),
   .rsp_last_char (rsp.last_char)
);

@@ dv/bae_address_checker.sv @@
// scoreboard of the bech32m address encoder: predicts each address character and compares
`timescale 1ns / 1ps

module bae_address_checker
   import bae_pkg::*;
#(
   parameter int unsigned PROGRAM_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   bae_req_if          req,
   bae_rsp_if          rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int unsigned mismatch_count,
   output int unsigned chars_pending
);

   localparam logic [6:0]  FIRST_CHAR_INIT  = 7'd98;
   localparam logic [6:0]  SECOND_CHAR_INIT = 7'd99;
   localparam logic [4:0]  VERSION_INIT     = 5'd1;
   localparam logic [6:0]  SEPARATOR        = 7'h31;
   localparam logic [29:0] BECH32M_CONST    = 30'h2bc830a3;
   localparam logic [29:0] GENERATOR [0:4]  = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };
   localparam string CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } addr_char_type;

   addr_char_type expected_chars [$];
   int unsigned   mismatches = 0;

   logic [6:0]  first_char;
   logic [6:0]  second_char;
   logic [4:0]  version;

   logic [29:0] polymod;
   logic [3:0]  spare_bits;
   int unsigned spare_count;
   int unsigned byte_index;

   assign mismatch_count = mismatches;

   function automatic logic [29:0] polymod_step(input logic [29:0] chk, input logic [4:0] sym);
      logic [29:0] acc;
      acc = {chk[24:0], sym};
      for (int g = 0; g < 5; g++) begin
         if (chk[25 + g]) begin
            acc = acc ^ GENERATOR[g];
         end
      end
      return acc;
   endfunction

   function automatic logic [6:0] symbol_char(input logic [4:0] sym);
      return 7'(CHARSET[sym]);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: address mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic expect_char(input logic [6:0] code, input logic last);
      addr_char_type c;
      c.code = code;
      c.last = last;
      expected_chars.insert(expected_chars.size(), c);
   endtask

   // data symbol: folded into the checksum and emitted as a character
   task automatic expect_symbol(input logic [4:0] sym);
      polymod = polymod_step(polymod, sym);
      expect_char(symbol_char(sym), 1'b0);
   endtask

   task automatic clear_encoder_state();
      polymod     = 30'd1;
      spare_bits  = '0;
      spare_count = 0;
      byte_index  = 0;
   endtask

   task automatic encode_program_byte(input logic [7:0] pbyte);
      logic [11:0] acc;
      int unsigned nbits;
      logic [29:0] sum;
      if (byte_index == 0) begin
         clear_encoder_state();
         // expanded prefix: high bits, zero, low bits
         polymod = polymod_step(polymod, 5'(first_char >> 5));
         polymod = polymod_step(polymod, 5'(second_char >> 5));
         polymod = polymod_step(polymod, 5'd0);
         polymod = polymod_step(polymod, first_char[4:0]);
         polymod = polymod_step(polymod, second_char[4:0]);
         expect_char(first_char, 1'b0);
         expect_char(second_char, 1'b0);
         expect_char(SEPARATOR, 1'b0);
         expect_symbol(version);
      end
      acc   = {spare_bits, pbyte};
      nbits = spare_count + 8;
      while (nbits >= 5) begin
         nbits -= 5;
         expect_symbol(5'(acc >> nbits));
      end
      spare_bits  = 4'(acc & ((12'd1 << nbits) - 12'd1));
      spare_count = nbits;
      if (byte_index + 1 >= PROGRAM_BYTES) begin
         if (spare_count > 0) begin
            expect_symbol(5'({1'b0, spare_bits} << (5 - spare_count)));
         end
         repeat (6) polymod = polymod_step(polymod, 5'd0);
         sum = polymod ^ BECH32M_CONST;
         for (int k = 0; k < 6; k++) begin
            expect_char(symbol_char(5'(sum >> (5 * (5 - k)))), k == 5);
         end
         clear_encoder_state();
      end else begin
         byte_index++;
      end
   endtask

   task automatic check_char(input logic [6:0] code, input logic last);
      addr_char_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch($sformatf("unexpected character 0x%02h last %0b", code, last));
      end else begin
         want = expected_chars.pop_front();
         if (code !== want.code) begin
            report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h", code, want.code));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("last_char %0b, expected %0b", last, want.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         first_char  = FIRST_CHAR_INIT;
         second_char = SECOND_CHAR_INIT;
         version     = VERSION_INIT;
         clear_encoder_state();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               BAE_REG_PREFIX_FIRST:  first_char  = pwdata[6:0];
               BAE_REG_PREFIX_SECOND: second_char = pwdata[6:0];
               BAE_REG_VERSION:       version     = pwdata[4:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            encode_program_byte(req.program_byte);
         end
         if (rsp.valid && rsp.ready) begin
            check_char(rsp.char_code, rsp.last_char);
         end
      end
      chars_pending <= expected_chars.size();
   end

endmodule

@@ dv/tb_bech32m_address_encoder_unit.sv @@
// testbench top of the bech32m address encoder: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_bech32m_address_encoder_unit
   import bae_pkg::*;
();

   localparam int unsigned PROGRAM_BYTES = 32;
   // register slot past the end of the list, writes there are dropped
   localparam logic [1:0]  CSR_SPARE_INDEX = 2'd3;
   // cycles with no accepted item before the run is declared hung
   localparam int unsigned IDLE_LIMIT = 3000;
   // long receiver hold-off, placed in the middle of the third address
   localparam int unsigned HOLD_AFTER  = 150;
   localparam int unsigned HOLD_CYCLES = 400;
   // quiet cycles after the last character before touching registers
   localparam int unsigned SETTLE_CYCLES = 8;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int unsigned mismatch_count;
   int unsigned chars_pending;
   int          sender_mode;
   logic [7:0]  program_bytes [PROGRAM_BYTES];

   bae_req_if req_bus ();
   bae_rsp_if rsp_bus ();

   bech32m_address_encoder_unit #(
      .PROGRAM_BYTES(PROGRAM_BYTES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   bae_address_checker #(
      .PROGRAM_BYTES(PROGRAM_BYTES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle draw per item: mode 0 never idles, mode 1 idles longest,
   // mode 2 idles briefly; the mode wanders so stretches of each appear
   function automatic int unsigned draw_gap(input int mode);
      case (mode)
         0:       return 0;
         1:       return $urandom_range(0, 18);
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   function automatic int next_mode(input int mode);
      if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(0, 2);
      end
      return mode;
   endfunction

   // apb write: setup phase, access phase until pready, then back to idle
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper bits carry random junk, the block keeps only the field
   task automatic set_prefix_and_version(input logic [6:0] first, input logic [6:0] second,
                                         input logic [4:0] ver);
      csr_write(BAE_REG_PREFIX_FIRST, ($urandom & ~32'h7f) | 32'(first));
      csr_write(BAE_REG_PREFIX_SECOND, ($urandom & ~32'h7f) | 32'(second));
      csr_write(BAE_REG_VERSION, ($urandom & ~32'h1f) | 32'(ver));
   endtask

   // random program with extra weight on all-zero and all-one bytes
   task automatic fill_random_program();
      for (int i = 0; i < PROGRAM_BYTES; i++) begin
         case ($urandom_range(0, 3))
            0:       program_bytes[i] = 8'h00;
            1:       program_bytes[i] = 8'hff;
            default: program_bytes[i] = 8'($urandom);
         endcase
      end
   endtask

   // offers one whole program; valid stays high across back-to-back items
   task automatic send_program();
      int unsigned gap;
      for (int i = 0; i < PROGRAM_BYTES; i++) begin
         gap = draw_gap(sender_mode);
         sender_mode = next_mode(sender_mode);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_bus.valid        <= 1'b1;
         req_bus.program_byte <= program_bytes[i];
         do @(posedge clock); while (!req_bus.ready);
      end
      req_bus.valid <= 1'b0;
   endtask

   // wait for every predicted character, then let the block go quiet
   task automatic drain();
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // main stimulus
   initial begin
      logic [7:0] corner_bytes [8];
      corner_bytes = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h7f, 8'hfe, 8'h55, 8'haa};
      sender_mode          = 0;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.program_byte <= 8'h00;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes up front, reset prefix "bc" and version 1
      fill_random_program();
      for (int i = 0; i < 8; i++) begin
         program_bytes[i] = corner_bytes[i];
      end
      send_program();

      // lowest printable first char, highest second, version 0;
      // a write past the register list must change nothing
      drain();
      set_prefix_and_version(7'd33, 7'd126, 5'd0);
      csr_write(CSR_SPARE_INDEX, $urandom);
      fill_random_program();
      send_program();

      // opposite extremes, top version
      drain();
      set_prefix_and_version(7'd126, 7'd33, 5'd31);
      fill_random_program();
      send_program();

      // prefix chars outside the printable range go through unchecked
      drain();
      set_prefix_and_version(7'd0, 7'd127, 5'($urandom));
      fill_random_program();
      send_program();

      // ordinary random setting
      drain();
      set_prefix_and_version(7'($urandom_range(33, 126)), 7'($urandom_range(33, 126)),
                             5'($urandom));
      fill_random_program();
      send_program();

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // receiver: random stalls, plus one long hold-off so the input backs up
   initial begin
      int unsigned stall;
      int unsigned taken;
      int          mode;
      bit          held;
      taken = 0;
      mode  = 1;
      held  = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && taken >= HOLD_AFTER) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else begin
            stall = draw_gap(mode);
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         taken++;
         mode = next_mode(mode);
      end
   end

   // watchdog: any accepted item or register access restarts the count
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel
             || reset) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ bech32m_address_encoder_unit.f @@
sv/bae_pkg.sv
sv/bae_ifs.sv
sv/bae_front.sv
sv/bae_queue.sv
sv/bae_back.sv
sv/bech32m_address_encoder_unit.sv
sv/bae_checker.sv
dv/bae_address_checker.sv
dv/tb_bech32m_address_encoder_unit.sv
